// ----- rtl/gclf_pkg.sv -----
// Shared types, character codes and helpers for the g-code line character filter.
// No dependencies.
package gclf_pkg;

  localparam int unsigned LINE_CAPACITY = 128;
  localparam int unsigned CNT_W         = $clog2(LINE_CAPACITY);

  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_MASK  = 8'hDF;

  typedef enum logic [2:0] {
    VERDICT_OVERFLOW = 3'd0,
    VERDICT_EMPTY    = 3'd1,
    VERDICT_SYSTEM   = 3'd2,
    VERDICT_ALARM    = 3'd3,
    VERDICT_GCODE    = 3'd4
  } verdict_e;

  typedef enum logic {
    KIND_CHAR    = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       alarm_locked;
  } item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] kept_char;
    logic [6:0] char_index;
    logic [6:0] line_length;
    verdict_e   verdict;
  } result_t;

  // Low 7 bits of a line count, zero-extended when the count is narrower.
  function automatic logic [6:0] count_to_7(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+6:0] wide;
    wide = {7'b0, cnt};
    return wide[6:0];
  endfunction

endpackage

// ----- rtl/gclf_in_reg.sv -----
// Input register for the g-code line character filter.
// Depends on gclf_pkg.
module gclf_in_reg import gclf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  input  logic  advance_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  // Slot frees up in the same cycle the held item moves on.
  assign in_ready_o = !valid_q || advance_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

// ----- rtl/gclf_filter.sv -----
// Per-line filter state and classification of one byte.
// Depends on gclf_pkg.
module gclf_filter import gclf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  output logic    res_valid_o,
  output result_t res_o
);

  logic             paren_q, paren_d;
  logic             semi_q, semi_d;
  logic             ovf_q, ovf_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       first_q, first_d;

  logic       eol, in_comment, drop, full;
  logic [7:0] ch, up_ch;

  assign ch         = item_i.rx_byte;
  assign eol        = (ch == CH_LF) || (ch == CH_CR);
  assign in_comment = paren_q || semi_q || ovf_q;
  assign drop       = (ch <= CH_SPACE) || (ch == CH_SLASH);
  assign full       = (count_q >= CNT_W'(LINE_CAPACITY - 1));
  assign up_ch      = ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z)) ? (ch & CASE_MASK) : ch;

  always_comb begin
    paren_d     = paren_q;
    semi_d      = semi_q;
    ovf_d       = ovf_q;
    count_d     = count_q;
    first_d     = first_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_CHAR, kept_char: 8'h00, char_index: 7'd0,
                    line_length: 7'd0, verdict: VERDICT_OVERFLOW};

    priority if (eol) begin
      res_valid_o       = 1'b1;
      res_o.kind        = KIND_VERDICT;
      res_o.line_length = count_to_7(count_q);
      priority if (ovf_q) begin
        res_o.verdict = VERDICT_OVERFLOW;
      end else if (count_q == '0) begin
        res_o.verdict = VERDICT_EMPTY;
      end else if (first_q == CH_DOLLAR) begin
        res_o.verdict = VERDICT_SYSTEM;
      end else if (item_i.alarm_locked) begin
        res_o.verdict = VERDICT_ALARM;
      end else begin
        res_o.verdict = VERDICT_GCODE;
      end
      paren_d = 1'b0;
      semi_d  = 1'b0;
      ovf_d   = 1'b0;
      count_d = '0;
      first_d = 8'h00;
    end else if (in_comment) begin
      // ')' closes a paren comment at any nesting; other flags stay
      if (ch == CH_RPAREN) begin
        paren_d = 1'b0;
      end
    end else if (drop) begin
      // whitespace, control and block-delete characters vanish
    end else if (ch == CH_LPAREN) begin
      paren_d = 1'b1;
    end else if (ch == CH_SEMI) begin
      semi_d = 1'b1;
    end else if (full) begin
      ovf_d = 1'b1;
    end else begin
      res_valid_o      = 1'b1;
      res_o.kind       = KIND_CHAR;
      res_o.kept_char  = up_ch;
      res_o.char_index = count_to_7(count_q);
      count_d          = count_q + 1'b1;
      if (count_q == '0) begin
        first_d = up_ch;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paren_q <= 1'b0;
      semi_q  <= 1'b0;
      ovf_q   <= 1'b0;
      count_q <= '0;
      first_q <= 8'h00;
    end else if (step_i) begin
      paren_q <= paren_d;
      semi_q  <= semi_d;
      ovf_q   <= ovf_d;
      count_q <= count_d;
      first_q <= first_d;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(LINE_CAPACITY - 1))
    else $error("line count past capacity");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (count_q == CNT_W'(LINE_CAPACITY - 1)))
    else $error("overflow flagged before line was full");

  a_eol_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && eol) |=> (count_q == '0) && !paren_q && !semi_q && !ovf_q)
    else $error("line state not cleared after end of line");

  a_first_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (first_q == 8'h00))
    else $error("first character held for an empty line");
`endif

endmodule

// ----- rtl/gclf_out_reg.sv -----
// Result register for the g-code line character filter.
// Depends on gclf_pkg.
module gclf_out_reg import gclf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    free_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ----- rtl/gcode_line_char_filter.sv -----
// G-code line character filter: input stage, filter and result stage.
// Depends on gclf_pkg, gclf_in_reg, gclf_filter, gclf_out_reg.
//
// Input channel: one received byte per transfer (rx_byte_i, alarm_locked_i).
// Output channel: at most one result per byte. A kept byte comes out as
// result_kind_o = 0 with kept_char_o and char_index_o; a line feed or
// carriage return comes out as result_kind_o = 1 with line_length_o and
// line_verdict_o (0 overflow, 1 empty, 2 system, 3 alarm, 4 g-code).
// Dropped bytes give no result. alarm_locked_i matters only at line end.
// Path: a transferred byte is registered in the input register, and the filter
// logic then loads its result into the result register, from which it is valid.
// Throughput: one byte per cycle while the output is taken; the only loop is
// the update of the per-line state from one byte.
// Stall: while out_ready_i is low the result is held, the input register
// still takes one more byte, and that byte waits there even if it gives no result.
// Reset clears the line state (empty line, no comment, no overflow) and both
// registers; no item is held afterwards.
module gcode_line_char_filter import gclf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       alarm_locked_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       result_kind_o,
  output logic [7:0] kept_char_o,
  output logic [6:0] char_index_o,
  output logic [6:0] line_length_o,
  output logic [2:0] line_verdict_o
);

  item_t   item_in, item_q;
  logic    item_valid, advance, out_free, res_valid, load;
  result_t res, res_q;

  assign item_in = '{rx_byte: rx_byte_i, alarm_locked: alarm_locked_i};

  // A held byte moves on when the result register can take its result.
  assign advance = item_valid && out_free;
  assign load    = advance && res_valid;

  gclf_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item_in),
    .advance_i  (advance),
    .valid_o    (item_valid),
    .item_o     (item_q)
  );

  gclf_filter u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (item_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  gclf_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_q)
  );

  assign result_kind_o  = res_q.kind;
  assign kept_char_o    = res_q.kept_char;
  assign char_index_o   = res_q.char_index;
  assign line_length_o  = res_q.line_length;
  assign line_verdict_o = res_q.verdict;

endmodule

// ----- bench/gcode_line_char_filter_test.sv -----
// Self-checking testbench for gcode_line_char_filter: random and directed command lines.
// Depends on gclf_pkg and the gcode_line_char_filter RTL; nothing else.
module gcode_line_char_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gclf_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int ITEM_GOAL    = 2000;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 10;

  // Directed lines: empty, system, alarm-blocked, g-code with comments, open comment.
  localparam int DIRECTED_LEN  = 26;
  localparam int GCODE_EOL_AT  = 23;
  localparam logic [7:0] DIRECTED [DIRECTED_LEN] = '{
    CH_LF,
    CH_DOLLAR, "h", CH_CR,
    "g", "0", CH_SPACE, CH_LF,
    8'h00, 8'h7F, 8'hFF, CH_LOWER_A, CH_LOWER_Z, CH_SLASH, CH_RPAREN,
    CH_LPAREN, CH_LPAREN, "q", CH_RPAREN, "x", CH_SEMI, CH_RPAREN, "y", CH_LF,
    CH_LPAREN, CH_CR
  };

  class line_filter_scoreboard;
    result_t     pending_results[$];
    bit          in_paren;
    bit          in_semicolon;
    bit          overflowed;
    int unsigned kept;
    logic [7:0]  first_char;
    int          errors;
    int          taken;

    function void clear_line();
      in_paren     = 1'b0;
      in_semicolon = 1'b0;
      overflowed   = 1'b0;
      kept         = 0;
      first_char   = 8'h00;
    endfunction

    function new();
      clear_line();
      errors = 0;
      taken  = 0;
    endfunction

    // Advance the line state by one transferred byte and queue what it yields.
    function void take_byte(logic [7:0] rx, logic alarm);
      result_t    r;
      logic [7:0] c;
      r = '0;
      taken++;
      if (rx == CH_LF || rx == CH_CR) begin
        r.kind        = KIND_VERDICT;
        r.line_length = kept[6:0];
        if (overflowed) r.verdict = VERDICT_OVERFLOW;
        else if (kept == 0) r.verdict = VERDICT_EMPTY;
        else if (first_char == CH_DOLLAR) r.verdict = VERDICT_SYSTEM;
        else if (alarm) r.verdict = VERDICT_ALARM;
        else r.verdict = VERDICT_GCODE;
        pending_results.push_back(r);
        clear_line();
        return;
      end
      if (in_paren || in_semicolon || overflowed) begin
        if (rx == CH_RPAREN) in_paren = 1'b0;
        return;
      end
      if (rx <= CH_SPACE || rx == CH_SLASH) return;
      if (rx == CH_LPAREN) begin
        in_paren = 1'b1;
        return;
      end
      if (rx == CH_SEMI) begin
        in_semicolon = 1'b1;
        return;
      end
      if (kept >= LINE_CAPACITY - 1) begin
        overflowed = 1'b1;
        return;
      end
      c = rx;
      if (c >= CH_LOWER_A && c <= CH_LOWER_Z) c = c - 8'h20;
      if (kept == 0) first_char = c;
      r.kind       = KIND_CHAR;
      r.kept_char  = c;
      r.char_index = kept[6:0];
      pending_results.push_back(r);
      kept++;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d char %h index %0d length %0d verdict %0d",
               got.kind, got.kept_char, got.char_index, got.line_length, got.verdict);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind) begin
        $error("result_kind: expected %0d, actual %0d", want.kind, got.kind);
        errors++;
      end
      if (got.kept_char !== want.kept_char) begin
        $error("kept_char: expected %h, actual %h", want.kept_char, got.kept_char);
        errors++;
      end
      if (got.char_index !== want.char_index) begin
        $error("char_index: expected %0d, actual %0d", want.char_index, got.char_index);
        errors++;
      end
      if (got.line_length !== want.line_length) begin
        $error("line_length: expected %0d, actual %0d", want.line_length, got.line_length);
        errors++;
      end
      if (got.verdict !== want.verdict) begin
        $error("line_verdict: expected %0d, actual %0d", want.verdict, got.verdict);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i      = 8'h00;
  logic       alarm_locked_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic       result_kind_o;
  logic [7:0] kept_char_o;
  logic [6:0] char_index_o;
  logic [6:0] line_length_o;
  logic [2:0] line_verdict_o;

  line_filter_scoreboard board = new();

  bit calm;       // no random gaps on either side while set
  bit hold_req;   // asks the receiver for one long hold-off
  int idle_cycles = 0;

  gcode_line_char_filter DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .rx_byte_i,
    .alarm_locked_i,
    .out_valid_o,
    .out_ready_i,
    .result_kind_o,
    .kept_char_o,
    .char_index_o,
    .line_length_o,
    .line_verdict_o
  );

  always #4 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_char(bit long_line);
    int         k;
    logic [7:0] c;
    k = long_line ? $urandom_range(0, 64) : $urandom_range(0, 99);
    if (k < 35) begin
      if ($urandom_range(0, 1)) c = 8'h41 + 8'($urandom_range(0, 25));
      else c = 8'h30 + 8'($urandom_range(0, 9));
    end else if (k < 60) begin
      c = CH_LOWER_A + 8'($urandom_range(0, 25));
    end else if (k < 68) begin
      do c = 8'($urandom_range(0, 32)); while (c == CH_LF || c == CH_CR);
    end else if (k < 72) begin
      c = CH_LPAREN;
    end else if (k < 77) begin
      c = CH_RPAREN;
    end else if (k < 79) begin
      c = CH_SEMI;
    end else if (k < 81) begin
      c = CH_SLASH;
    end else begin
      do c = 8'($urandom_range(0, 255)); while (c == CH_LF || c == CH_CR);
    end
    return c;
  endfunction

  task automatic send_byte(logic [7:0] b, logic alarm);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    rx_byte_i      <= b;
    alarm_locked_i <= alarm;
    do @(posedge clk_i); while (!in_ready_o);
    board.take_byte(b, alarm);
  endtask

  task automatic send_line();
    int r;
    int len;
    bit long_line;
    r         = $urandom_range(0, 99);
    long_line = (r >= 88);
    len       = long_line ? $urandom_range(120, 140) : $urandom_range(0, 18);
    for (int i = 0; i < len; i++) begin
      if (i == 0 && $urandom_range(0, 6) == 0) send_byte(CH_DOLLAR, 1'($urandom));
      else send_byte(pick_char(long_line), 1'($urandom));
    end
    send_byte($urandom_range(0, 1) ? CH_LF : CH_CR, 1'($urandom));
  endtask

  initial begin
    bit pressure_done;
    pressure_done = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < DIRECTED_LEN; i++) begin
      send_byte(DIRECTED[i], (i == GCODE_EOL_AT) ? 1'b0 : 1'b1);
    end
    while (board.taken < ITEM_GOAL) begin
      if (board.taken >= 900 && !pressure_done) begin
        calm          = 1'b1;
        hold_req      = 1'b1;
        pressure_done = 1'b1;
      end
      if (board.taken >= 1300) calm = 1'b0;
      send_line();
    end
    in_valid_i <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Receiver: bursts of ready separated by random stalls, plus one long hold-off.
  initial begin
    int burst;
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      burst = $urandom_range(1, 30);
      out_ready_i <= 1'b1;
      repeat (burst) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : capture_result
    result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.kind        = kind_e'(result_kind_o);
      got.kept_char   = kept_char_o;
      got.char_index  = char_index_o;
      got.line_length = line_length_o;
      got.verdict     = verdict_e'(line_verdict_o);
      board.check_result(got);
    end
  end

  // Any transfer on either channel resets the stall counter.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
